// ===== rtl/srb_pkg.sv =====
// ----------------------------------------------------------------------------
// srb_pkg
// shared types, constants and helpers of the sequence ring buffer
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam int NUM_SLOTS  = 256;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int DATA_WIDTH = 32;
  localparam int SEQ_W      = 16;
  localparam int REQ_W      = 3;
  localparam int IDX_W      = 8;

  localparam logic [SEQ_W-1:0] HALF_RANGE = SEQ_W'(32768);
  localparam logic [SEQ_W-1:0] SEQ_SLOTS  = SEQ_W'(NUM_SLOTS);

  // request codes on the input port
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FIND   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RESET  = 3'd4;

  // classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_WRITE,
    OP_STALE,
    OP_REMOVE,
    OP_FIND,
    OP_READ,
    OP_RESET,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic                  clr_all;
    logic                  clr_span;
    logic [SLOT_W-1:0]     clr_cnt;
    logic [SLOT_W-1:0]     first;
    logic [SLOT_W-1:0]     slot;
    logic [SEQ_W-1:0]      seq;
    logic                  oor;
    logic [DATA_WIDTH-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic                  accepted;
    logic                  hit;
    logic                  slot_empty;
    logic [DATA_WIDTH-1:0] read_data;
  } res_t;

  typedef enum logic [0:0] {
    B_IDLE,
    B_EXEC
  } bstate_t;

  // wrapping compare: a is newer than b
  function automatic logic seq_newer(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return ((d != '0) && (d < HALF_RANGE)) || ((d == HALF_RANGE) && (a > b));
  endfunction

endpackage

// ===== rtl/srb_front.sv =====
// ----------------------------------------------------------------------------
// srb_front
// accepts requests, tracks the next sequence and classifies each request
// ----------------------------------------------------------------------------
module srb_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [srb_pkg::REQ_W-1:0]       req_type,
  input  logic [srb_pkg::SEQ_W-1:0]       seq_num,
  input  logic [srb_pkg::IDX_W-1:0]       slot_index,
  input  logic [srb_pkg::DATA_WIDTH-1:0]  write_data,
  output srb_pkg::cmd_t                   cmd_head,
  output logic                            cmd_avail,
  input  logic                            cmd_pop
);

  logic [srb_pkg::SEQ_W-1:0] next_seq;
  logic [srb_pkg::SEQ_W-1:0] next_seq_next;
  srb_pkg::cmd_t             cmd_in;
  logic                      take;

  srb_pkg::cmd_t q [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;

  logic [srb_pkg::SEQ_W-1:0] seq_inc;
  logic [srb_pkg::SEQ_W-1:0] span;
  logic [srb_pkg::SEQ_W-1:0] oldest;

  assign full      = (count == 2'd2);
  assign cmd_avail = (count != 2'd0);
  assign cmd_head  = q[rptr];
  assign take      = push && !full;

  assign seq_inc = seq_num + 1'b1;
  assign span    = seq_num - next_seq;
  assign oldest  = next_seq - srb_pkg::SEQ_SLOTS;

  always_comb begin
    cmd_in          = '0;
    cmd_in.op       = srb_pkg::OP_BAD;
    cmd_in.seq      = seq_num;
    cmd_in.slot     = seq_num[srb_pkg::SLOT_W-1:0];
    cmd_in.first    = next_seq[srb_pkg::SLOT_W-1:0];
    cmd_in.clr_cnt  = span[srb_pkg::SLOT_W-1:0];
    cmd_in.data     = write_data;
    next_seq_next   = next_seq;
    case (req_type)
      srb_pkg::REQ_INSERT: begin
        if (srb_pkg::seq_newer(seq_inc, next_seq)) begin
          cmd_in.op       = srb_pkg::OP_WRITE;
          cmd_in.clr_all  = (span >= srb_pkg::SEQ_SLOTS);
          cmd_in.clr_span = (span < srb_pkg::SEQ_SLOTS);
          next_seq_next   = seq_inc;
        end else if (srb_pkg::seq_newer(oldest, seq_num)) begin
          cmd_in.op = srb_pkg::OP_STALE;
        end else begin
          cmd_in.op = srb_pkg::OP_WRITE;
        end
      end
      srb_pkg::REQ_REMOVE: cmd_in.op = srb_pkg::OP_REMOVE;
      srb_pkg::REQ_FIND:   cmd_in.op = srb_pkg::OP_FIND;
      srb_pkg::REQ_READ: begin
        cmd_in.op   = srb_pkg::OP_READ;
        cmd_in.slot = srb_pkg::SLOT_W'(slot_index);
        cmd_in.oor  = (32'(slot_index) >= 32'(srb_pkg::NUM_SLOTS));
      end
      srb_pkg::REQ_RESET: begin
        cmd_in.op     = srb_pkg::OP_RESET;
        next_seq_next = '0;
      end
      default: cmd_in.op = srb_pkg::OP_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_seq <= '0;
      wptr     <= 1'b0;
      rptr     <= 1'b0;
      count    <= 2'd0;
    end else begin
      if (take) begin
        next_seq <= next_seq_next;
        wptr     <= !wptr;
      end
      if (cmd_pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(take) - 2'(cmd_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q[wptr] <= cmd_in;
    end
  end

endmodule

// ===== rtl/srb_back.sv =====
// ----------------------------------------------------------------------------
// srb_back
// executes classified requests against the valid bits, tag and data stores
// ----------------------------------------------------------------------------
module srb_back (
  input  logic          clk,
  input  logic          rst,
  input  srb_pkg::cmd_t cmd_head,
  input  logic          cmd_avail,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output srb_pkg::res_t res
);

  srb_pkg::bstate_t state;
  srb_pkg::bstate_t state_next;
  srb_pkg::cmd_t    cur;

  logic [srb_pkg::NUM_SLOTS-1:0]  valid;
  logic [srb_pkg::NUM_SLOTS-1:0]  valid_next;
  logic [srb_pkg::SEQ_W-1:0]      tag_mem  [srb_pkg::NUM_SLOTS];
  logic [srb_pkg::DATA_WIDTH-1:0] data_mem [srb_pkg::NUM_SLOTS];
  logic [srb_pkg::SEQ_W-1:0]      tag_rd;
  logic [srb_pkg::DATA_WIDTH-1:0] data_rd;

  logic [srb_pkg::SLOT_W-1:0] ptr;
  logic [srb_pkg::SLOT_W-1:0] rem;

  logic go;
  logic clear_step;
  logic do_write;
  logic do_clear_all;
  logic do_remove;
  logic slot_vld;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      srb_pkg::B_IDLE: if (cmd_avail) state_next = srb_pkg::B_EXEC;
      srb_pkg::B_EXEC: if (res_push) state_next = srb_pkg::B_IDLE;
      default:         state_next = srb_pkg::B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_pop      = 1'b0;
    go           = 1'b0;
    res_push     = 1'b0;
    clear_step   = 1'b0;
    do_write     = 1'b0;
    do_clear_all = 1'b0;
    do_remove    = 1'b0;
    case (state)
      srb_pkg::B_IDLE: cmd_pop = cmd_avail;
      srb_pkg::B_EXEC: begin
        go = !res_full;
        if (go) begin
          case (cur.op)
            srb_pkg::OP_WRITE: begin
              clear_step   = cur.clr_span;
              do_clear_all = cur.clr_all;
              do_write     = !cur.clr_span || (rem == '0);
              res_push     = do_write;
            end
            srb_pkg::OP_REMOVE: begin
              do_remove = 1'b1;
              res_push  = 1'b1;
            end
            srb_pkg::OP_RESET: begin
              do_clear_all = 1'b1;
              res_push     = 1'b1;
            end
            default: res_push = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
  end

  // valid bits: clears first, a write to the same slot wins
  always_comb begin
    valid_next = valid;
    if (do_clear_all) valid_next = '0;
    if (clear_step) valid_next[ptr] = 1'b0;
    if (do_remove) valid_next[cur.slot] = 1'b0;
    if (do_write) valid_next[cur.slot] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srb_pkg::B_IDLE;
      valid <= '0;
    end else begin
      state <= state_next;
      valid <= valid_next;
    end
  end

  // command latch and span sweep pointers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd_head;
      ptr <= cmd_head.first;
      rem <= cmd_head.clr_cnt;
    end else if (clear_step) begin
      ptr <= ptr + 1'b1;
      rem <= rem - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      tag_mem[cur.slot]  <= cur.seq;
      data_mem[cur.slot] <= cur.data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      tag_rd  <= tag_mem[cmd_head.slot];
      data_rd <= data_mem[cmd_head.slot];
    end
  end

  assign slot_vld = valid[cur.slot];

  always_comb begin
    res = '0;
    case (cur.op)
      srb_pkg::OP_STALE: res.accepted = 1'b0;
      srb_pkg::OP_BAD:   res.accepted = 1'b0;
      srb_pkg::OP_FIND: begin
        res.accepted   = 1'b1;
        res.hit        = slot_vld && (tag_rd == cur.seq);
        res.slot_empty = !slot_vld;
      end
      srb_pkg::OP_READ: begin
        res.accepted   = 1'b1;
        res.hit        = slot_vld && !cur.oor;
        res.slot_empty = !(slot_vld && !cur.oor);
      end
      default: res.accepted = 1'b1;
    endcase
    res.read_data = res.hit ? data_rd : '0;
  end

endmodule

// ===== rtl/sequence_ring_buffer_core.sv =====
// ----------------------------------------------------------------------------
// sequence_ring_buffer_core
// ring of slots addressed by 16-bit sequence number, with insert, remove,
// find, read by slot and reset requests
// ----------------------------------------------------------------------------
// flow: the back end pops a request in its idle state and pushes its result beat from
//   its exec state, stalling while the result queue is full; an insert that jumps ahead by k
//   sequences (k below the slot count) first steps the single valid-bit sweep in
//   the back end over the skipped slots; no new request is taken before the result is pushed
// reset: synchronous rst empties both queues, sets next sequence to zero and
//   marks every slot invalid; no clearing pass is needed
// ----------------------------------------------------------------------------
module sequence_ring_buffer_core (
  input  logic                           clk,
  input  logic                           rst,
  // request side
  input  logic                           push,
  output logic                           full,
  input  logic [srb_pkg::REQ_W-1:0]      req_type,
  input  logic [srb_pkg::SEQ_W-1:0]      seq_num,
  input  logic [srb_pkg::IDX_W-1:0]      slot_index,
  input  logic [srb_pkg::DATA_WIDTH-1:0] write_data,
  // result side
  output logic                           empty,
  input  logic                           pop,
  output logic                           accepted,
  output logic                           hit,
  output logic                           slot_empty,
  output logic [srb_pkg::DATA_WIDTH-1:0] read_data
);

  // front to back command queue head
  srb_pkg::cmd_t cmd_head;
  logic          cmd_avail;
  logic          cmd_pop;

  // back end result beat
  srb_pkg::res_t res;
  logic          res_push;
  logic          res_full;

  // two-entry result queue decouples the back end from the consumer
  srb_pkg::res_t rq [2];
  logic          rq_wptr;
  logic          rq_rptr;
  logic [1:0]    rq_count;
  logic          rq_pop;

  srb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .seq_num    (seq_num),
    .slot_index (slot_index),
    .write_data (write_data),
    .cmd_head   (cmd_head),
    .cmd_avail  (cmd_avail),
    .cmd_pop    (cmd_pop)
  );

  srb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_head  (cmd_head),
    .cmd_avail (cmd_avail),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  assign res_full = (rq_count == 2'd2);
  assign empty    = (rq_count == 2'd0);
  assign rq_pop   = pop && !empty;

  // oldest waiting result beat drives the ports
  assign accepted   = rq[rq_rptr].accepted;
  assign hit        = rq[rq_rptr].hit;
  assign slot_empty = rq[rq_rptr].slot_empty;
  assign read_data  = rq[rq_rptr].read_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wptr  <= 1'b0;
      rq_rptr  <= 1'b0;
      rq_count <= 2'd0;
    end else begin
      if (res_push) rq_wptr <= !rq_wptr;
      if (rq_pop) rq_rptr <= !rq_rptr;
      rq_count <= rq_count + 2'(res_push) - 2'(rq_pop);
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (res_push) begin
      rq[rq_wptr] <= res;
    end
  end

endmodule

// ===== test/sequence_ring_buffer_core_tb.sv =====
// ----------------------------------------------------------------------------
// sequence_ring_buffer_core_tb
// self-checking bench for the sequence ring buffer: a directed table of
// requests (wrap, stale, span clear, remove, reset, unused codes) followed by
// random packet-like traffic, every result beat compared in order against a
// software copy of the ring, with random idling on both queue sides and one
// long result stall that backs the request queue up
// ----------------------------------------------------------------------------
module sequence_ring_buffer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srb_pkg::*;

  // codes the block must answer with an all-zero beat
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  localparam int RANDOM_BEATS = 650;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 20;
  // one long receiver stall once this many results are in
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 600;
  // stretches with no idling, counted in beats
  localparam int QUIET_SEND_LO = 300;
  localparam int QUIET_SEND_HI = 450;
  localparam int QUIET_RECV_LO = 350;
  localparam int QUIET_RECV_HI = 500;

  // answers that can be read off at a glance
  localparam res_t RES_DONE  = '{accepted: 1'b1, hit: 1'b0, slot_empty: 1'b0, read_data: '0};
  localparam res_t RES_EMPTY = '{accepted: 1'b1, hit: 1'b0, slot_empty: 1'b1, read_data: '0};
  localparam res_t RES_ZERO  = '0;

  typedef struct packed {
    logic [REQ_W-1:0]      req;
    logic [SEQ_W-1:0]      seq;
    logic [IDX_W-1:0]      idx;
    logic [DATA_WIDTH-1:0] data;
    logic                  typed;   // use want instead of the ring copy
    res_t                  want;
  } ring_req_t;

  localparam int DIRECTED_N = 26;

  // directed walk; the sequence comments give the expected next sequence
  ring_req_t directed_rows [DIRECTED_N] = '{
    // fresh after reset: nothing valid
    '{REQ_FIND,   16'd0,     8'd17,  32'h0000_0001, 1'b1, RES_EMPTY},
    '{REQ_READ,   16'hFFFF,  8'd0,   32'hFFFF_FFFF, 1'b1, RES_EMPTY},
    // first insert, data extremes, next -> 1 then 2
    '{REQ_INSERT, 16'd0,     8'd255, 32'hFFFF_FFFF, 1'b1, RES_DONE},
    '{REQ_FIND,   16'd0,     8'd0,   32'd0, 1'b1,
      '{accepted: 1'b1, hit: 1'b1, slot_empty: 1'b0, read_data: 32'hFFFF_FFFF}},
    '{REQ_INSERT, 16'd1,     8'd0,   32'h0000_0000, 1'b1, RES_DONE},
    '{REQ_READ,   16'd0,     8'd1,   32'd0, 1'b1,
      '{accepted: 1'b1, hit: 1'b1, slot_empty: 1'b0, read_data: 32'd0}},
    // late top-of-range sequence, kept without advancing
    '{REQ_INSERT, 16'hFFFF,  8'd0,   32'hA5A5_A5A5, 1'b0, RES_ZERO},
    '{REQ_READ,   16'd0,     8'd255, 32'd0,         1'b0, RES_ZERO},
    // jump wider than the ring clears every slot, next -> 301
    '{REQ_INSERT, 16'd300,   8'd0,   32'h1234_5678, 1'b0, RES_ZERO},
    '{REQ_FIND,   16'd0,     8'd0,   32'd0,         1'b0, RES_ZERO},
    // older than the window: stale
    '{REQ_INSERT, 16'd40,    8'd0,   32'hDEAD_BEEF, 1'b1, RES_ZERO},
    '{REQ_INSERT, 16'd45,    8'd0,   32'hCAFE_F00D, 1'b0, RES_ZERO},
    '{REQ_REMOVE, 16'd45,    8'd0,   32'd0,         1'b1, RES_DONE},
    '{REQ_FIND,   16'd45,    8'd0,   32'd0,         1'b0, RES_ZERO},
    // exactly half range ahead still counts as newer
    '{REQ_INSERT, 16'd33068, 8'd0,   32'h0F0F_0F0F, 1'b0, RES_ZERO},
    // sequence past 65535 wraps next to zero
    '{REQ_INSERT, 16'hFFFF,  8'd0,   32'hF0F0_F0F0, 1'b0, RES_ZERO},
    '{REQ_INSERT, 16'd0,     8'd0,   32'h5A5A_5A5A, 1'b0, RES_ZERO},
    // same slot, other tag
    '{REQ_FIND,   16'd256,   8'd0,   32'd0,         1'b0, RES_ZERO},
    '{REQ_RESET,  16'hFFFF,  8'd255, 32'hFFFF_FFFF, 1'b1, RES_DONE},
    // walk next up to 65534, then a span clear that wraps through zero
    '{REQ_INSERT, 16'd32767, 8'd0,   32'h0000_0001, 1'b0, RES_ZERO},
    '{REQ_INSERT, 16'd65533, 8'd0,   32'h0000_0002, 1'b0, RES_ZERO},
    '{REQ_INSERT, 16'hFFFF,  8'd0,   32'h0000_0003, 1'b0, RES_ZERO},
    '{REQ_INSERT, 16'd1,     8'd0,   32'h0000_0004, 1'b0, RES_ZERO},
    '{REQ_READ,   16'd0,     8'd255, 32'd0,         1'b0, RES_ZERO},
    // unused request codes
    '{REQ_UNUSED_LO, 16'hFFFF, 8'd255, 32'hFFFF_FFFF, 1'b1, RES_ZERO},
    '{REQ_UNUSED_HI, 16'd0,    8'd0,   32'd0,         1'b1, RES_ZERO}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic [REQ_W-1:0]      req_type = '0;
  logic [SEQ_W-1:0]      seq_num = '0;
  logic [IDX_W-1:0]      slot_index = '0;
  logic [DATA_WIDTH-1:0] write_data = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic                  accepted;
  logic                  hit;
  logic                  slot_empty;
  logic [DATA_WIDTH-1:0] read_data;

  // software copy of the ring
  logic [SEQ_W-1:0]      ring_next;
  logic                  ring_valid [NUM_SLOTS];
  logic [SEQ_W-1:0]      ring_tag   [NUM_SLOTS];
  logic [DATA_WIDTH-1:0] ring_data  [NUM_SLOTS];

  res_t pending_results [$];
  int   mismatch_count = 0;
  int   beats_sent = 0;
  int   results_seen = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   cycles = 0;

  sequence_ring_buffer_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .seq_num    (seq_num),
    .slot_index (slot_index),
    .write_data (write_data),
    .empty      (empty),
    .pop        (pop),
    .accepted   (accepted),
    .hit        (hit),
    .slot_empty (slot_empty),
    .read_data  (read_data)
  );

  always #5 clk = ~clk;

  // wrap-around order: a is ahead of b by at most half the sequence space
  function automatic bit wraps_ahead(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    return (a > b && (a - b) <= HALF_RANGE) || (a < b && (b - a) > HALF_RANGE);
  endfunction

  function automatic void ring_clear();
    foreach (ring_valid[i]) ring_valid[i] = 1'b0;
  endfunction

  // applies one request to the ring copy and returns its result beat
  function automatic res_t ring_apply(ring_req_t rq);
    res_t             r;
    logic [SEQ_W-1:0] seq_inc;
    logic [SEQ_W-1:0] span;
    logic [SEQ_W-1:0] window_lo;
    logic [SLOT_W-1:0] slot;
    bit               keep;
    r = '0;
    r.accepted = 1'b1;
    seq_inc = rq.seq + 16'd1;
    window_lo = ring_next - SEQ_SLOTS;
    slot = rq.seq[SLOT_W-1:0];
    case (rq.req)
      REQ_INSERT: begin
        keep = 1'b1;
        if (wraps_ahead(seq_inc, ring_next)) begin
          // invalidate every sequence skipped over, wrapping through zero
          span = rq.seq - ring_next;
          if (span < NUM_SLOTS) begin
            for (int k = 0; k <= span; k++) begin
              ring_valid[SLOT_W'(ring_next + SEQ_W'(k))] = 1'b0;
            end
          end else begin
            ring_clear();
          end
          ring_next = seq_inc;
        end else if (wraps_ahead(window_lo, rq.seq)) begin
          keep = 1'b0;
          r.accepted = 1'b0;
        end
        if (keep) begin
          ring_valid[slot] = 1'b1;
          ring_tag[slot] = rq.seq;
          ring_data[slot] = rq.data;
        end
      end
      REQ_REMOVE: ring_valid[slot] = 1'b0;
      REQ_FIND: begin
        r.slot_empty = !ring_valid[slot];
        r.hit = ring_valid[slot] && (ring_tag[slot] == rq.seq);
        if (r.hit) r.read_data = ring_data[slot];
      end
      REQ_READ: begin
        // slot_index cannot exceed the ring here, so no out-of-range case
        r.hit = ring_valid[rq.idx];
        r.slot_empty = !ring_valid[rq.idx];
        if (r.hit) r.read_data = ring_data[rq.idx];
      end
      REQ_RESET: begin
        ring_next = '0;
        ring_clear();
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // packet-like traffic: mostly in-order inserts near the head of the ring,
  // lookups of recent sequences, and a thin layer of jumps and noise
  function automatic ring_req_t pick_random_req();
    ring_req_t rq;
    int        roll;
    rq.req = REQ_INSERT;
    rq.seq = SEQ_W'($urandom);
    rq.idx = IDX_W'($urandom);
    rq.data = $urandom;
    rq.typed = 1'b0;
    rq.want = '0;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      rq.seq = ring_next + SEQ_W'($urandom_range(0, 2));
    end else if (roll < 53) begin
      // late or stale packets
      rq.seq = ring_next - SEQ_W'($urandom_range(1, 300));
    end else if (roll < 56) begin
      // big jumps, some past half range
      rq.seq = ring_next + SEQ_W'($urandom_range(3, 40000));
    end else if (roll < 60) begin
      rq.req = REQ_INSERT;
    end else if (roll < 75) begin
      rq.req = REQ_FIND;
      rq.seq = ring_next - SEQ_W'($urandom_range(1, 280));
    end else if (roll < 80) begin
      rq.req = REQ_FIND;
    end else if (roll < 88) begin
      rq.req = REQ_READ;
    end else if (roll < 94) begin
      rq.req = REQ_REMOVE;
      rq.seq = ring_next - SEQ_W'($urandom_range(1, 260));
    end else if (roll < 96) begin
      rq.req = REQ_REMOVE;
    end else if (roll < 98) begin
      rq.req = REQ_RESET;
    end else begin
      rq.req = REQ_UNUSED_LO + REQ_W'($urandom_range(0, 2));
    end
    if ($urandom_range(0, 15) == 0) rq.data = $urandom_range(0, 1) ? '1 : '0;
    return rq;
  endfunction

  // offers one request beat, idling now and then, and records its answer
  // once the block takes it
  task automatic send_req(ring_req_t rq);
    res_t model_res;
    bit   quiet;
    quiet = beats_sent >= QUIET_SEND_LO && beats_sent < QUIET_SEND_HI;
    while (!quiet && $urandom_range(0, 99) < 17) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req_type <= rq.req;
    seq_num <= rq.seq;
    slot_index <= rq.idx;
    write_data <= rq.data;
    // the beat goes in at the first edge that sees full low
    do @(posedge clk); while (full);
    model_res = ring_apply(rq);
    pending_results.push_back(rq.typed ? rq.want : model_res);
    beats_sent++;
  endtask

  // compare one popped result beat with the oldest expectation
  task automatic check_result();
    res_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result beat with nothing outstanding: acc=%0b hit=%0b empty=%0b data=%h",
               $time, accepted, hit, slot_empty, read_data);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      if (accepted !== want.accepted) begin
        $display("%0t: accepted expected %0b actual %0b", $time, want.accepted, accepted);
        mismatch_count++;
      end
      if (hit !== want.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
        mismatch_count++;
      end
      if (slot_empty !== want.slot_empty) begin
        $display("%0t: slot_empty expected %0b actual %0b", $time, want.slot_empty, slot_empty);
        mismatch_count++;
      end
      if (read_data !== want.read_data) begin
        $display("%0t: read_data expected %h actual %h", $time, want.read_data, read_data);
        mismatch_count++;
      end
    end
    results_seen++;
  endtask

  // result side: random pops, one quiet stretch, one long stall
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result();
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        // sender keeps going, so the request queue fills and full rises
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        pop <= 1'b0;
      end else if (results_seen >= QUIET_RECV_LO && results_seen < QUIET_RECV_HI) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 99) >= 17);
      end
    end
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    ring_next = '0;
    ring_clear();
    foreach (ring_data[i]) ring_data[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_req(directed_rows[i]);
    repeat (RANDOM_BEATS) send_req(pick_random_req());
    push <= 1'b0;

    // let the last beats come out, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
